[rtl/three_wheel_odometry_defines.svh]
// ----------------------------------------------------------------------------
// three_wheel_odometry_defines
// assertion macros used by the odometry top level
// ----------------------------------------------------------------------------
`ifndef THREE_WHEEL_ODOMETRY_DEFINES_SVH
`define THREE_WHEEL_ODOMETRY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TWODO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TWODO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/twodo_pkg.sv]
// ----------------------------------------------------------------------------
// twodo_pkg
// shared types, constants and helpers of the three-wheel odometry block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twodo_pkg;

  localparam int MUL_W  = 32;
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 16;

  // 2*pi in q3.29
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;

  // register indexes
  localparam logic [2:0] REG_DIST_PER_COUNT = 3'd0;
  localparam logic [2:0] REG_ANGLE_PER_DIST = 3'd1;
  localparam logic [2:0] REG_FRONT_OFFSET   = 3'd2;
  localparam logic [2:0] REG_INITIAL_X      = 3'd3;
  localparam logic [2:0] REG_INITIAL_Y      = 3'd4;
  localparam logic [2:0] REG_INITIAL_HEAD   = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // sequencer steps, in program order
  typedef enum logic [5:0] {
    ST_DL, ST_DR, ST_DS, ST_DTH, ST_P, ST_HI, ST_LO, ST_X, ST_X2,
    ST_S72, ST_S42M, ST_S42D, ST_S20M, ST_S20D, ST_S6M, ST_S6D, ST_SX,
    ST_C90, ST_C56M, ST_C56D, ST_C30M, ST_C30D, ST_C12M, ST_C12D, ST_C2M, ST_C2D,
    ST_FC, ST_LS, ST_FS, ST_LC, ST_VX, ST_VY, ST_VH
  } step_t;

  function automatic logic [31:0] sat32(input logic [64:0] v);
    logic [31:0] r;
    if (!v[64] && (v[63:31] != '0)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[64] && (v[63:31] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

[rtl/twodo_mul.sv]
// ----------------------------------------------------------------------------
// twodo_mul
// shift-add unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twodo_mul
  import twodo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output unit_stat_t         stat,
  output logic [2*MUL_W-1:0] prod
);

  localparam int CW = $clog2(MUL_W);

  logic [MUL_W-1:0]   mcand;
  logic [2*MUL_W-1:0] acc;
  logic [MUL_W:0]     sum;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               done;

  assign sum = {1'b0, acc[2*MUL_W-1:MUL_W]} + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MUL_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc   <= {{MUL_W{1'b0}}, b};
    end else if (busy) begin
      acc <= {sum, acc[MUL_W-1:1]};
    end
  end

  assign stat = '{busy: busy, done: done};
  assign prod = acc;

endmodule

[rtl/twodo_div.sv]
// ----------------------------------------------------------------------------
// twodo_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twodo_div
  import twodo_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output unit_stat_t        stat,
  output logic [DIV_NW-1:0] quo
);

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] q;
  logic [DIV_DW+1:0] trial;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;

  assign trial = {1'b0, rem, q[DIV_NW-1]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // q shifts the dividend out at the top and the quotient in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= den;
      rem <= '0;
      q   <= num;
    end else if (busy) begin
      if (!trial[DIV_DW+1]) begin
        rem <= trial[DIV_DW-1:0];
      end else begin
        rem <= {rem[DIV_DW-2:0], q[DIV_NW-1]};
      end
      q <= {q[DIV_NW-2:0], ~trial[DIV_DW+1]};
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quo  = q;

endmodule

[rtl/three_wheel_odometry.sv]
// ----------------------------------------------------------------------------
// three_wheel_odometry
// dead-reckoning pose tracker for two parallel and one sideways encoder
// ----------------------------------------------------------------------------
// one beat in gives one pose beat out. a sequencer walks a fixed program over
// one shared shift-add multiplier and one shared restoring divider: wheel
// scaling, heading change, offset compensation, sine/cosine by folded taylor
// series, rotation and per-tick velocity, the last left out when the interval
// is zero. a new beat is taken only once the last item has run its program and
// its result is loaded. the result sits in an output register, so the block
// is ready for the next beat while the last result waits; a stalled result
// holds the following item at its end. s_tready is high only between items.
// configuration writes are taken only between items (cfg_ready is high in
// idle); writing an initial pose register also loads that pose coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_wheel_odometry_defines.svh"

module three_wheel_odometry
  import twodo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // config write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input beats
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_count, right_count, side_count, interval
  input  logic [111:0] s_tdata,
  // result beats
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, heading, vel_x, vel_y, vel_heading
  output logic [191:0] m_tdata,
  // interval_error
  output logic [0:0]   m_tuser
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ISSUE = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  phase_t phase;
  step_t  step;

  // config registers
  logic [23:0] dist_per_count;
  logic [31:0] angle_per_dist;
  logic [31:0] front_offset;

  // block state
  logic [31:0] last_left, last_right, last_side;
  logic [31:0] pose_x, pose_y, pose_heading;

  // captured item
  logic [31:0] in_l, in_r, in_s;
  logic [15:0] in_iv;

  // working registers
  logic [31:0] dl, dr, ds, dth, lat;
  logic [63:0] pm, t6, acc;
  logic        pneg;
  logic [31:0] x, x2, sv, cv, tmp;
  logic [33:0] dx, dy;
  logic [31:0] vx, vy, vh;
  logic        op_neg;

  // output register
  logic [191:0] out_data;
  logic         out_err;

  // unit wiring
  logic               mul_start, div_start;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               use_div, issue_neg;
  unit_stat_t         mul_stat, div_stat;
  logic [2*MUL_W-1:0] prod;
  logic [DIV_NW-1:0]  quo;

  twodo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (prod)
  );

  twodo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (quo)
  );

  // count deltas, wrapping
  logic [31:0] dlt_l, dlt_r, dlt_s;
  assign dlt_l = in_l - last_left;
  assign dlt_r = in_r - last_right;
  assign dlt_s = in_s - last_side;

  // forward motion and wheel difference from the scaled distances
  logic [32:0] fwd_sum;
  logic [31:0] fwd, diff;
  assign fwd_sum = {dl[31], dl} + {dr[31], dr};
  assign fwd     = fwd_sum[32:1];
  assign diff    = sat32({{33{dr[31]}}, dr} - {{33{dl[31]}}, dl});

  // octant folding of the previous heading
  logic [2:0]  oct;
  logic [29:0] rfold;
  logic [31:0] s0, c0;
  logic        sn_neg, cs_neg;
  logic [31:0] sn_mag, cs_mag;
  assign oct   = pose_heading[31:29];
  assign rfold = oct[0] ? (30'h2000_0000 - {1'b0, pose_heading[28:0]})
                        : {1'b0, pose_heading[28:0]};
  assign s0    = oct[0] ? cv : sv;
  assign c0    = oct[0] ? sv : cv;

  always_comb begin
    sn_mag = s0;
    cs_mag = c0;
    sn_neg = 1'b0;
    cs_neg = 1'b0;
    case (oct[2:1])
      2'd0: begin
        sn_mag = s0; cs_mag = c0;
      end
      2'd1: begin
        sn_mag = c0; cs_mag = s0; cs_neg = 1'b1;
      end
      2'd2: begin
        sn_mag = s0; cs_mag = c0; sn_neg = 1'b1; cs_neg = 1'b1;
      end
      default: begin
        sn_mag = c0; cs_mag = s0; sn_neg = 1'b1;
      end
    endcase
  end

  logic [33:0] dx_mag, dy_mag;
  assign dx_mag = dx[33] ? (~dx + 34'd1) : dx;
  assign dy_mag = dy[33] ? (~dy + 34'd1) : dy;

  // operand selection for the step about to issue
  always_comb begin
    use_div   = 1'b0;
    issue_neg = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = 16'd1;
    case (step)
      ST_DL: begin
        mul_a = abs32(dlt_l); mul_b = {8'd0, dist_per_count}; issue_neg = dlt_l[31];
      end
      ST_DR: begin
        mul_a = abs32(dlt_r); mul_b = {8'd0, dist_per_count}; issue_neg = dlt_r[31];
      end
      ST_DS: begin
        mul_a = abs32(dlt_s); mul_b = {8'd0, dist_per_count}; issue_neg = dlt_s[31];
      end
      ST_DTH: begin
        mul_a = abs32(diff); mul_b = angle_per_dist; issue_neg = diff[31];
      end
      ST_P: begin
        mul_a = abs32(front_offset); mul_b = abs32(dth);
        issue_neg = front_offset[31] ^ dth[31];
      end
      ST_HI: begin
        mul_a = pm[63:32]; mul_b = TWO_PI_Q29;
      end
      ST_LO: begin
        mul_a = pm[31:0]; mul_b = TWO_PI_Q29;
      end
      ST_X: begin
        mul_a = {2'b00, rfold}; mul_b = TWO_PI_Q29;
      end
      ST_X2: begin
        mul_a = x; mul_b = x;
      end
      ST_S72: begin
        use_div = 1'b1; div_num = {8'd0, x2}; div_den = 16'd72;
      end
      ST_S42M, ST_S20M, ST_S6M: begin
        mul_a = x2; mul_b = sv;
      end
      ST_S42D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd42;
      end
      ST_S20D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd20;
      end
      ST_S6D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd6;
      end
      ST_SX: begin
        mul_a = x; mul_b = sv;
      end
      ST_C90: begin
        use_div = 1'b1; div_num = {8'd0, x2}; div_den = 16'd90;
      end
      ST_C56M, ST_C30M, ST_C12M, ST_C2M: begin
        mul_a = x2; mul_b = cv;
      end
      ST_C56D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd56;
      end
      ST_C30D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd30;
      end
      ST_C12D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd12;
      end
      ST_C2D: begin
        use_div = 1'b1; div_num = {8'd0, tmp}; div_den = 16'd2;
      end
      ST_FC: begin
        mul_a = abs32(fwd); mul_b = cs_mag; issue_neg = fwd[31] ^ cs_neg;
      end
      ST_LS: begin
        mul_a = abs32(lat); mul_b = sn_mag; issue_neg = lat[31] ^ sn_neg;
      end
      ST_FS: begin
        mul_a = abs32(fwd); mul_b = sn_mag; issue_neg = fwd[31] ^ sn_neg;
      end
      ST_LC: begin
        mul_a = abs32(lat); mul_b = cs_mag; issue_neg = lat[31] ^ cs_neg;
      end
      ST_VX: begin
        use_div = 1'b1; div_num = {6'd0, dx_mag}; div_den = in_iv; issue_neg = dx[33];
      end
      ST_VY: begin
        use_div = 1'b1; div_num = {6'd0, dy_mag}; div_den = in_iv; issue_neg = dy[33];
      end
      ST_VH: begin
        use_div = 1'b1; div_num = {8'd0, abs32(dth)}; div_den = in_iv;
        issue_neg = dth[31];
      end
      default: begin
        use_div = 1'b0;
      end
    endcase
  end

  assign mul_start = (phase == PH_ISSUE) && !use_div;
  assign div_start = (phase == PH_ISSUE) && use_div;

  // signed views of the unit results
  logic [64:0] pz, sprod, qz, squo;
  assign pz    = {1'b0, prod};
  assign sprod = op_neg ? (~pz + 65'd1) : pz;
  assign qz    = {25'd0, quo};
  assign squo  = op_neg ? (~qz + 65'd1) : qz;

  // rotation compensation of the sideways wheel
  logic [63:0] msum;
  logic [64:0] magz, comp, latv;
  assign msum = t6 + {32'd0, prod[63:32]};
  assign magz = {30'd0, msum[63:29]};
  assign comp = pneg ? (~magz + 65'd1) : magz;
  assign latv = {{33{ds[31]}}, ds} - comp;

  logic [63:0] dx_acc, dy_acc;
  assign dx_acc = acc - sprod[63:0];
  assign dy_acc = acc + sprod[63:0];

  logic unit_done, last_step;
  assign unit_done = mul_stat.done || div_stat.done;
  assign last_step = (step == ST_VH) || ((step == ST_LC) && (in_iv == '0));

  // working registers take the finished unit result
  always_ff @(posedge clk) begin
    if ((phase == PH_ISSUE)) begin
      op_neg <= issue_neg;
    end
    if ((phase == PH_WAIT) && unit_done) begin
      case (step)
        ST_DL:  dl  <= sat32(sprod);
        ST_DR:  dr  <= sat32(sprod);
        ST_DS:  ds  <= sat32(sprod);
        ST_DTH: dth <= sprod[63:32];
        ST_P: begin
          pm   <= prod;
          pneg <= op_neg;
        end
        ST_HI:  t6  <= prod;
        ST_LO:  lat <= sat32(latv);
        ST_X:   x   <= prod[62:31];
        ST_X2:  x2  <= prod[61:30];
        ST_S72, ST_S42D, ST_S20D, ST_S6D: sv <= Q30_ONE - quo[31:0];
        ST_S42M, ST_S20M, ST_S6M, ST_C56M, ST_C30M, ST_C12M, ST_C2M: tmp <= prod[61:30];
        ST_SX:  sv  <= prod[61:30];
        ST_C90, ST_C56D, ST_C30D, ST_C12D, ST_C2D: cv <= Q30_ONE - quo[31:0];
        ST_FC, ST_FS: acc <= sprod[63:0];
        ST_LS:  dx  <= dx_acc[63:30];
        ST_LC:  dy  <= dy_acc[63:30];
        ST_VX:  vx  <= sat32(squo);
        ST_VY:  vy  <= sat32(squo);
        ST_VH:  vh  <= sat32(squo);
        default: begin
          tmp <= tmp;
        end
      endcase
    end
  end

  // next pose
  logic [31:0] pose_x_next, pose_y_next, pose_heading_next;
  logic        zero_iv;
  assign pose_x_next       = pose_x + dx[31:0];
  assign pose_y_next       = pose_y + dy[31:0];
  assign pose_heading_next = pose_heading + dth;
  assign zero_iv           = (in_iv == '0);

  logic out_load;
  assign out_load = (phase == PH_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_l  <= s_tdata[31:0];
      in_r  <= s_tdata[63:32];
      in_s  <= s_tdata[95:64];
      in_iv <= s_tdata[111:96];
    end
    if (out_load) begin
      out_data <= {zero_iv ? 32'd0 : vh, zero_iv ? 32'd0 : vy, zero_iv ? 32'd0 : vx,
                   pose_heading_next, pose_y_next, pose_x_next};
      out_err  <= zero_iv;
    end
  end

  // sequencer, config and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      step           <= ST_DL;
      m_tvalid       <= 1'b0;
      dist_per_count <= 24'd65536;
      angle_per_dist <= 32'd1;
      front_offset   <= '0;
      last_left      <= '0;
      last_right     <= '0;
      last_side      <= '0;
      pose_x         <= '0;
      pose_y         <= '0;
      pose_heading   <= '0;
    end else begin
      // a new result takes the output register as the old one leaves
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (phase)
        PH_IDLE: begin
          if (s_tvalid) begin
            step  <= ST_DL;
            phase <= PH_ISSUE;
          end
        end
        PH_ISSUE: begin
          phase <= PH_WAIT;
        end
        PH_WAIT: begin
          if (unit_done) begin
            if (last_step) begin
              phase <= PH_DONE;
            end else begin
              step  <= step_t'(step + 6'd1);
              phase <= PH_ISSUE;
            end
          end
        end
        PH_DONE: begin
          if (out_load) begin
            pose_x       <= pose_x_next;
            pose_y       <= pose_y_next;
            pose_heading <= pose_heading_next;
            last_left    <= in_l;
            last_right   <= in_r;
            last_side    <= in_s;
            phase        <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
      // register writes, only in idle; unknown indexes drop
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIST_PER_COUNT: dist_per_count <= cfg_data[23:0];
          REG_ANGLE_PER_DIST: angle_per_dist <= cfg_data;
          REG_FRONT_OFFSET:   front_offset   <= cfg_data;
          REG_INITIAL_X:      pose_x         <= cfg_data;
          REG_INITIAL_Y:      pose_y         <= cfg_data;
          REG_INITIAL_HEAD:   pose_heading   <= cfg_data;
          default: begin
            front_offset <= front_offset;
          end
        endcase
      end
    end
  end

  assign cfg_ready = (phase == PH_IDLE);
  assign s_tready  = (phase == PH_IDLE);
  assign m_tdata   = out_data;
  assign m_tuser   = out_err;

  // the units are never busy together
  `TWODO_ASSERT_IMP(a_one_unit, 1'b1, !(mul_stat.busy && div_stat.busy), "both units busy")
  // a unit result only arrives while the sequencer waits for it
  `TWODO_ASSERT_IMP(a_done_in_wait, unit_done, phase == PH_WAIT, "unit done outside wait")
  // an accepted beat starts the program at its first step
  `TWODO_ASSERT_NXT(a_start_prog, s_tvalid && s_tready,
                    (phase == PH_ISSUE) && (step == ST_DL), "program did not start")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the three-wheel odometry block
// ----------------------------------------------------------------------------
// a pose tracker class predicts every result beat from the accepted encoder
// beats and the register writes, and compares it field by field. a directed
// burst covers count and interval extremes, zero interval and saturation.
// random phases follow, each with fresh register settings (extremes among
// them) and its own sender gap and receiver stall mix. most random beats are
// plausible motion; the rest bring arbitrary counts, a zero interval, or no motion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import twodo_pkg::*;

  typedef struct {
    bit [31:0] px, py, hd, vx, vy, vh;
    bit        ierr;
  } pose_beat_t;

  class pose_tracker;
    bit [23:0] dist_per_count;
    bit [31:0] angle_per_dist, front_off;
    bit [31:0] prev_left, prev_right, prev_side;
    bit [31:0] pose_x, pose_y, pose_hd;
    pose_beat_t pending[$];
    int errors;
    int matched;
    int zero_ivs;

    function new();
      dist_per_count = 24'd65536;
      angle_per_dist = 32'd1;
      front_off = '0;
      prev_left = '0; prev_right = '0; prev_side = '0;
      pose_x = '0; pose_y = '0; pose_hd = '0;
      errors = 0; matched = 0; zero_ivs = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] d);
      case (idx)
        REG_DIST_PER_COUNT: dist_per_count = d[23:0];
        REG_ANGLE_PER_DIST: angle_per_dist = d;
        REG_FRONT_OFFSET:   front_off = d;
        REG_INITIAL_X:      pose_x = d;
        REG_INITIAL_Y:      pose_y = d;
        REG_INITIAL_HEAD:   pose_hd = d;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint scaled_delta(bit [31:0] now, bit [31:0] last);
      bit [31:0] d;
      d = now - last;
      return clamp32(longint'($signed(d)) * longint'(dist_per_count));
    endfunction

    // q2.30 sine/cosine by octant fold and truncated taylor series
    function void sin_cos(bit [31:0] a, output longint sn, output longint cs);
      longint unsigned r, x, x2, s, c, one;
      longint s0, c0;
      one = 64'd1 << 30;
      r = a[28:0];
      if (a[29]) r = (64'd1 << 29) - r;
      x = (r * 64'(TWO_PI_Q29)) >> 31;
      x2 = (x * x) >> 30;
      s = one - x2 / 72;
      s = one - ((x2 * s) >> 30) / 42;
      s = one - ((x2 * s) >> 30) / 20;
      s = one - ((x2 * s) >> 30) / 6;
      s = (x * s) >> 30;
      c = one - x2 / 90;
      c = one - ((x2 * c) >> 30) / 56;
      c = one - ((x2 * c) >> 30) / 30;
      c = one - ((x2 * c) >> 30) / 12;
      c = one - ((x2 * c) >> 30) / 2;
      if (a[29]) begin
        s0 = longint'(c); c0 = longint'(s);
      end else begin
        s0 = longint'(s); c0 = longint'(c);
      end
      case (a[31:30])
        2'd0: begin sn = s0;  cs = c0;  end
        2'd1: begin sn = c0;  cs = -s0; end
        2'd2: begin sn = -s0; cs = -c0; end
        default: begin sn = -c0; cs = s0; end
      endcase
    endfunction

    function void note_input(bit [31:0] l, bit [31:0] r, bit [31:0] sd, bit [15:0] iv);
      longint dl, dr, ds, fwd, diff, dth, p, comp, lat, sn, cs, dx, dy, ivl;
      longint unsigned m, hi, lo;
      pose_beat_t e;
      dl = scaled_delta(l, prev_left);
      dr = scaled_delta(r, prev_right);
      ds = scaled_delta(sd, prev_side);
      fwd = (dl + dr) >>> 1;
      diff = clamp32(dr - dl);
      dth = (diff * longint'(angle_per_dist)) >>> 32;
      // rotation compensation of the sideways wheel, magnitude truncated
      p = longint'($signed(front_off)) * dth;
      m = (p < 0) ? longint'(-p) : p;
      hi = (m >> 32) * 64'(TWO_PI_Q29);
      lo = (m & 64'hFFFF_FFFF) * 64'(TWO_PI_Q29);
      comp = longint'((hi + (lo >> 32)) >> 29);
      if (p < 0) comp = -comp;
      lat = clamp32(ds - comp);
      sin_cos(pose_hd, sn, cs);
      dx = (fwd * cs - lat * sn) >>> 30;
      dy = (fwd * sn + lat * cs) >>> 30;
      pose_x = pose_x + dx[31:0];
      pose_y = pose_y + dy[31:0];
      pose_hd = pose_hd + dth[31:0];
      prev_left = l; prev_right = r; prev_side = sd;
      ivl = longint'(iv);
      e.px = pose_x; e.py = pose_y; e.hd = pose_hd;
      if (iv == 0) begin
        e.vx = '0; e.vy = '0; e.vh = '0; e.ierr = 1'b1;
        zero_ivs++;
      end else begin
        e.vx = 32'(clamp32(dx / ivl));
        e.vy = 32'(clamp32(dy / ivl));
        e.vh = 32'(clamp32(dth / ivl));
        e.ierr = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function bit field_ok(string nm, bit [31:0] exp_v, bit [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %h got %h", $time, nm, exp_v, act_v);
        return 0;
      end
      return 1;
    endfunction

    function void check_result(bit [191:0] d, bit [0:0] u);
      pose_beat_t e;
      bit ok;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing pending, data %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      ok = 1;
      ok &= field_ok("pos_x", e.px, d[31:0]);
      ok &= field_ok("pos_y", e.py, d[63:32]);
      ok &= field_ok("heading", e.hd, d[95:64]);
      ok &= field_ok("vel_x", e.vx, d[127:96]);
      ok &= field_ok("vel_y", e.vy, d[159:128]);
      ok &= field_ok("vel_heading", e.vh, d[191:160]);
      ok &= field_ok("interval_error", 32'(e.ierr), 32'(u));
      if (ok) matched++;
      else errors++;
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [191:0] m_tdata;
  logic [0:0]   m_tuser;

  pose_tracker tracker;
  int gap_pct;
  int stall_pct;
  int beats_sent;
  int cfg_writes;
  // counts driven last, so well-formed beats can move a little from there
  bit [31:0] cur_left, cur_right, cur_side;

  three_wheel_odometry u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: stall pattern redrawn every falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result beats checked at the rising edge they are taken
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
  end

  task automatic write_cfg(bit [2:0] idx, bit [31:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one encoder beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(bit [31:0] l, bit [31:0] r, bit [31:0] sd, bit [15:0] iv);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {iv, sd, r, l};
    do @(posedge clk); while (!s_tready);
    tracker.note_input(l, r, sd, iv);
    cur_left = l; cur_right = r; cur_side = sd;
    beats_sent++;
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      // mostly short gaps, sometimes one long enough to land mid-item
      gap = ($urandom_range(9) == 0) ? $urandom_range(1400) : $urandom_range(30);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] pick32(int sel);
    case (sel)
      0: return 32'h0000_0001;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int n);
    int k;
    bit [15:0] iv;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3) == 0 ? $urandom_range(3) : 4)
        0: send_beat($urandom(), $urandom(), $urandom(), 16'($urandom()));
        1: send_beat(cur_left + 32'($urandom_range(1 << 20)) - 32'(1 << 19),
                     $urandom(), cur_side, 16'd0);
        2: send_beat(cur_left, cur_right, cur_side, 16'($urandom_range(3)));
        default: begin
          // plausible motion: small moves, some turning, usual intervals
          iv = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4000));
          send_beat(cur_left + 32'($urandom_range(8000)) - 32'd4000,
                    cur_right + 32'($urandom_range(8000)) - 32'd4000,
                    cur_side + 32'($urandom_range(4000)) - 32'd2000, iv);
        end
      endcase
    end
  endtask

  initial begin
    int ph;
    tracker = new();
    gap_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    cfg_writes = 0;
    cur_left = '0; cur_right = '0; cur_side = '0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset scaling, count and interval extremes, zero interval
    send_beat(32'd0, 32'd0, 32'd0, 16'd0);
    send_beat(32'd100, 32'd100, 32'd0, 16'd1);
    send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    send_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'd0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 16'd2);
    drain();
    // largest angle scale, largest front offset, preset heading and two unknown indexes
    write_cfg(REG_ANGLE_PER_DIST, 32'hFFFF_FFFF);
    write_cfg(REG_FRONT_OFFSET, 32'h7FFF_FFFF);
    write_cfg(REG_INITIAL_HEAD, 32'h2000_0000);
    write_cfg(3'd6, 32'hDEAD_BEEF);
    write_cfg(3'd7, 32'h1234_5678);
    for (ph = 0; ph < 9; ph++)
      send_beat(cur_left - 32'd1, cur_right + 32'd1, cur_side + 32'd3, 16'(ph));
    drain();
    write_cfg(REG_DIST_PER_COUNT, 32'h00FF_FFFF);
    write_cfg(REG_FRONT_OFFSET, 32'h8000_0000);
    write_cfg(REG_INITIAL_X, 32'h7FFF_FFFF);
    write_cfg(REG_INITIAL_Y, 32'h8000_0000);
    send_beat(cur_left + 32'd1000, cur_right - 32'd1000, cur_side + 32'd7, 16'd1);
    send_beat(cur_left, cur_right, cur_side - 32'd1000, 16'd0);
    send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 16'h8000);
    // zero scales give no motion at all
    drain();
    write_cfg(REG_DIST_PER_COUNT, 32'd0);
    write_cfg(REG_ANGLE_PER_DIST, 32'd0);
    send_beat(32'h1111_1111, 32'h9999_9999, 32'h5555_5555, 16'd3);
    // sender holds off here until the last result is back
    drain();

    // random phases: idle mix cycles through none, sender, receiver, both
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      write_cfg(REG_DIST_PER_COUNT, (ph == 1) ? 32'd1 : (ph == 5) ? 32'h00FF_FFFF :
                32'($urandom_range(1, 32'h0003_FFFF)));
      write_cfg(REG_ANGLE_PER_DIST, (ph == 2) ? 32'd1 : (ph == 6) ? 32'hFFFF_FFFF :
                $urandom_range(1, 32'h0100_0000));
      write_cfg(REG_FRONT_OFFSET, pick32($urandom_range(6)));
      write_cfg(REG_INITIAL_X, pick32($urandom_range(6)));
      write_cfg(REG_INITIAL_Y, pick32($urandom_range(6)));
      write_cfg(REG_INITIAL_HEAD, $urandom());
      random_phase(66);
      drain();
    end

    gap_pct = 0;
    stall_pct = 0;
    repeat (1300) @(negedge clk);
    $display("%0d encoder beats, %0d with zero interval, %0d register writes",
             beats_sent, tracker.zero_ivs, cfg_writes);
    $display("%0d result beats matched, %0d mismatched", tracker.matched, tracker.errors);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d results pending", tracker.pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
